/* design/ubh_pkg.sv */
// shared types, codes and constants of the uniform bin histogram
`timescale 1ns / 1ps

package ubh_pkg;

  // default number of count memory entries
  localparam int DEF_MAX_BINS = 1024;

  // divider steps, one quotient bit per step
  localparam int DIV_STEPS = 16;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // width of a bin index after clamping to the bins in use
  localparam int BIN_W = 11;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_LOWER_EDGE  = 2'd0,
    CFG_BIN_WIDTH   = 2'd1,
    CFG_BINS_IN_USE = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_CLEAR,
    ST_DIV,
    ST_LOOKUP,
    ST_READ,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] sample;
    logic [9:0]         read_bin;
  } item_t;

  typedef struct packed {
    logic [9:0]         bin_number;
    logic [31:0]        bin_count;
    logic signed [31:0] bin_lower_edge;
    logic               accepted;
  } result_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic clr_step;
    logic div_step;
    logic lookup;
    logic rd_mem;
    logic update;
    logic load_reject;
    logic load_clear;
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic neg;
    logic rd_oob;
    logic div_last;
    logic clr_last;
  } status_t;

endpackage

/* design/ubh_ram.sv */
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module ubh_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ubh_ctrl.sv */
// controller state machine of the histogram
`timescale 1ns / 1ps

module ubh_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ubh_pkg::status_t status_i,
  output ubh_pkg::ctrl_t   ctrl_o
);

  import ubh_pkg::*;

  state_e state_q, state_d;
  ctrl_t  ctrl;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    ctrl    = '0;
    unique case (state_q)
      ST_INIT: begin
        ctrl.clr_step = 1'b1;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          ctrl.accept = 1'b1;
          state_d     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (status_i.cmd)
          CMD_CLEAR: state_d = ST_CLEAR;
          CMD_ADD: begin
            if (status_i.neg) begin
              ctrl.load_reject = 1'b1;
              state_d          = ST_IDLE;
            end else begin
              state_d = ST_DIV;
            end
          end
          CMD_READ: begin
            if (status_i.rd_oob) begin
              ctrl.load_reject = 1'b1;
              state_d          = ST_IDLE;
            end else begin
              state_d = ST_LOOKUP;
            end
          end
          default: begin
            ctrl.load_reject = 1'b1;
            state_d          = ST_IDLE;
          end
        endcase
      end
      ST_CLEAR: begin
        ctrl.clr_step = 1'b1;
        if (status_i.clr_last) begin
          ctrl.load_clear = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_DIV: begin
        ctrl.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        ctrl.lookup = 1'b1;
        state_d     = ST_READ;
      end
      ST_READ: begin
        ctrl.rd_mem = 1'b1;
        state_d     = ST_WAIT;
      end
      ST_WAIT: begin
        ctrl.update = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ctrl_o = ctrl;
  assign busy   = (state_q != ST_IDLE);

  // an accepted item always moves to dispatch
  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.accept |=> state_q == ST_DISPATCH)
    else $error("accepted item did not reach dispatch");

  // the divider runs until its last step
  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !status_i.div_last) |=> state_q == ST_DIV)
    else $error("divider left early");

  // at most one result load per cycle
  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.update, ctrl.load_reject, ctrl.load_clear}))
    else $error("more than one result load");

  // no write sweep overlaps a divide, memory read or count update
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.clr_step && (ctrl.div_step || ctrl.rd_mem || ctrl.update)))
    else $error("sweep overlaps item work");

endmodule

/* design/ubh_datapath.sv */
// datapath of the histogram: registers, divider, count memory, results
`timescale 1ns / 1ps

module ubh_datapath #(
  parameter int MAX_BINS = ubh_pkg::DEF_MAX_BINS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  ubh_pkg::item_t   item_i,
  input  ubh_pkg::ctrl_t   ctrl_i,
  output ubh_pkg::status_t status_o,
  output ubh_pkg::result_t res_o,
  output logic             done_o
);

  import ubh_pkg::*;

  localparam int AW = $clog2(MAX_BINS);

  logic [15:0]       edge_q, width_q;
  logic [10:0]       bins_q;
  logic [15:0]       width_eff;
  logic [10:0]       n_raw, n_eff;

  cmd_e              cmd_q;
  logic [9:0]        rbin_q;
  logic              neg_q;
  logic [15:0]       rem_q, quo_q;
  logic [DIV_CW-1:0] div_cnt_q;
  logic [BIN_W-1:0]  bin_q, bin_clamp;
  logic [26:0]       prod_q;
  logic [AW-1:0]     clr_cnt_q;
  logic              clr_last;

  logic [16:0]       diff;
  logic [16:0]       shifted, trial;
  logic              ge;

  logic [BIN_W+AW-1:0] bin_ext;
  logic [AW-1:0]     bin_addr;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [31:0]       ram_wdata, rdata, inc;

  result_t           res_q;
  logic              done_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q  <= 16'd0;
      width_q <= 16'd1;
      bins_q  <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LOWER_EDGE:  edge_q  <= cfg_data_i;
        CFG_BIN_WIDTH:   width_q <= cfg_data_i;
        CFG_BINS_IN_USE: bins_q  <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // effective width and bin count
  always_comb begin
    width_eff = (width_q == 16'd0) ? 16'd1 : width_q;
    n_raw     = (bins_q == 11'd0) ? 11'd1 : bins_q;
    n_eff     = (int'(n_raw) > MAX_BINS) ? 11'(MAX_BINS) : n_raw;
  end

  // sample offset from the lower edge
  assign diff = {item_i.sample[15], item_i.sample} - {edge_q[15], edge_q};

  // restoring divider step
  always_comb begin
    shifted = {rem_q, quo_q[15]};
    ge      = (shifted >= {1'b0, width_eff});
    trial   = shifted - {1'b0, width_eff};
  end

  // item latch and divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (ctrl_i.accept) begin
      div_cnt_q <= '0;
    end else if (ctrl_i.div_step) begin
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q  <= cmd_e'(item_i.command);
      rbin_q <= item_i.read_bin;
      neg_q  <= diff[16];
      quo_q  <= diff[15:0];
      rem_q  <= '0;
    end else if (ctrl_i.div_step) begin
      rem_q <= ge ? trial[15:0] : shifted[15:0];
      quo_q <= {quo_q[14:0], ge};
    end
  end

  // clamp to the last bin, which is open above
  assign bin_clamp = ({5'b0, n_eff} <= quo_q) ? (n_eff - 11'd1) : quo_q[10:0];

  // bin index and edge offset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.lookup) begin
      bin_q <= (cmd_q == CMD_ADD) ? bin_clamp : {1'b0, rbin_q};
    end
    if (ctrl_i.rd_mem) begin
      prod_q <= {16'b0, bin_q} * {11'b0, width_eff};
    end
  end

  // clearing sweep address
  assign clr_last = (clr_cnt_q == AW'(MAX_BINS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctrl_i.clr_step) begin
      clr_cnt_q <= clr_last ? '0 : clr_cnt_q + 1'b1;
    end
  end

  // count memory access
  assign bin_ext   = {{AW{1'b0}}, bin_q};
  assign bin_addr  = bin_ext[AW-1:0];
  assign inc       = (rdata == 32'hFFFF_FFFF) ? rdata : rdata + 32'd1;
  assign ram_we    = ctrl_i.clr_step || (ctrl_i.update && cmd_q == CMD_ADD);
  assign ram_waddr = ctrl_i.clr_step ? clr_cnt_q : bin_addr;
  assign ram_wdata = ctrl_i.clr_step ? 32'd0 : inc;

  ubh_ram #(
    .Width(32),
    .Depth(MAX_BINS)
  ) u_counts (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ctrl_i.rd_mem),
    .raddr_i(bin_addr),
    .rdata_o(rdata)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      res_q.bin_number     <= bin_q[9:0];
      res_q.bin_count      <= (cmd_q == CMD_ADD) ? inc : rdata;
      res_q.bin_lower_edge <= {{16{edge_q[15]}}, edge_q} + {5'b0, prod_q};
      res_q.accepted       <= 1'b1;
    end else if (ctrl_i.load_reject) begin
      res_q.bin_number     <= (cmd_q == CMD_READ) ? rbin_q : 10'd0;
      res_q.bin_count      <= '0;
      res_q.bin_lower_edge <= '0;
      res_q.accepted       <= 1'b0;
    end else if (ctrl_i.load_clear) begin
      res_q.bin_number     <= '0;
      res_q.bin_count      <= '0;
      res_q.bin_lower_edge <= '0;
      res_q.accepted       <= 1'b1;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.update || ctrl_i.load_reject || ctrl_i.load_clear;
    end
  end

  // status to the controller
  always_comb begin
    status_o.cmd      = cmd_q;
    status_o.neg      = neg_q;
    status_o.rd_oob   = ({1'b0, rbin_q} >= n_eff);
    status_o.div_last = (div_cnt_q == DIV_CW'(DIV_STEPS - 1));
    status_o.clr_last = clr_last;
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

/* design/uniform_bin_histogram.sv */
// top level of the uniform bin histogram
// an add runs dispatch, the 16 step divider, lookup, memory read and update, a
// read all but the divider; a dropped sample, a read past the bins in use or an
// unused command is rejected at dispatch; a clear zeroes one count per cycle;
// one item at a time, next accept in the cycle the result shows; results cannot
// be stalled; after reset a clearing pass zeroes all MAX_BINS counts, busy high
`timescale 1ns / 1ps

module uniform_bin_histogram #(
  parameter int MAX_BINS = ubh_pkg::DEF_MAX_BINS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ubh_pkg::item_t   item_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  output ubh_pkg::result_t res_o,
  output logic             done_o
);

  import ubh_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // controller
  ubh_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .status_i(status),
    .ctrl_o  (ctrl)
  );

  // datapath
  ubh_datapath #(
    .MAX_BINS(MAX_BINS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .item_i    (item_i),
    .ctrl_i    (ctrl),
    .status_o  (status),
    .res_o     (res_o),
    .done_o    (done_o)
  );

endmodule
